// ===== src/assert_macros.svh =====
// assertion helpers for the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/spifcs_pkg.sv =====
package spifcs_pkg;

	localparam int MAX_RES = 7;
	localparam int CNT_W = 3;

	localparam logic [7:0] DUMMY_BYTE = 8'hA5;
	localparam int WIP_BIT = 0;

	typedef enum logic [3:0] {
		OP_READ_ID     = 4'd0,
		OP_READ_START  = 4'd1,
		OP_READ_BYTE   = 4'd2,
		OP_WRITE_START = 4'd3,
		OP_WRITE_BYTE  = 4'd4,
		OP_SECTOR_ERASE = 4'd5,
		OP_BLOCK_ERASE = 4'd6,
		OP_CHIP_ERASE  = 4'd7,
		OP_STATUS      = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_READ  = 2'd1,
		PH_WRITE = 2'd2,
		PH_POLL  = 2'd3
	} phase_t;

	localparam logic [1:0] RX_IGNORE = 2'd0;
	localparam logic [1:0] RX_DATA   = 2'd1;
	localparam logic [1:0] RX_STATUS = 2'd2;

	localparam logic [2:0] REG_WREN    = 3'd0;
	localparam logic [2:0] REG_RDSR    = 3'd1;
	localparam logic [2:0] REG_PP      = 3'd2;
	localparam logic [2:0] REG_READ    = 3'd3;
	localparam logic [2:0] REG_SE      = 3'd4;
	localparam logic [2:0] REG_BE      = 3'd5;
	localparam logic [2:0] REG_CE      = 3'd6;
	localparam logic [2:0] REG_RDID    = 3'd7;

	typedef struct packed {
		logic [7:0] op_write_enable;
		logic [7:0] op_read_status;
		logic [7:0] op_page_program;
		logic [7:0] op_read_data;
		logic [7:0] op_sector_erase;
		logic [7:0] op_block_erase;
		logic [7:0] op_chip_erase;
		logic [7:0] op_read_ident;
	} cfg_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       select_end;
		logic       release_only;
		logic [1:0] rx_use;
		logic       op_done;
		logic       rejected;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]          count;
		result_t [MAX_RES-1:0]     entry;
	} frame_t;

	function automatic result_t mk_res(input logic [7:0] tx, input logic se,
		input logic rel, input logic [1:0] rx, input logic done);
		result_t r;
		r.tx_byte      = tx;
		r.select_end   = se;
		r.release_only = rel;
		r.rx_use       = rx;
		r.op_done      = done;
		r.rejected     = 1'b0;
		return r;
	endfunction

endpackage

// ===== src/spifcs_frame.sv =====
module spifcs_frame #(
	parameter int PAGE_SIZE = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [3:0]          operation,
	input  logic [23:0]         address,
	input  logic [15:0]         length,
	input  logic [7:0]          data,
	input  spifcs_pkg::cfg_t    cfg,
	output spifcs_pkg::frame_t  frame
);

	localparam int PB = $clog2(PAGE_SIZE);

	spifcs_pkg::phase_t phase_q, phase_d;
	logic [23:0] addr_q, addr_d;
	logic [15:0] rem_q, rem_d;
	logic        poll_wr_q, poll_wr_d;

	logic [23:0] addr_inc;
	logic [15:0] rem_dec;
	logic        page_end;

	assign addr_inc = addr_q + 24'd1;
	assign rem_dec  = rem_q - 16'd1;
	assign page_end = (rem_dec == 16'd0) || (addr_inc[PB-1:0] == '0);

	always_comb begin
		frame     = '0;
		phase_d   = phase_q;
		addr_d    = addr_q;
		rem_d     = rem_q;
		poll_wr_d = poll_wr_q;
		case (operation)
			spifcs_pkg::OP_READ_ID: begin
				if (phase_q == spifcs_pkg::PH_IDLE) begin
					frame.count = 3'd4;
					frame.entry[0] = spifcs_pkg::mk_res(cfg.op_read_ident, 1'b0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[1] = spifcs_pkg::mk_res(spifcs_pkg::DUMMY_BYTE, 1'b0, 1'b0,
						spifcs_pkg::RX_DATA, 1'b0);
					frame.entry[2] = frame.entry[1];
					frame.entry[3] = spifcs_pkg::mk_res(spifcs_pkg::DUMMY_BYTE, 1'b1, 1'b0,
						spifcs_pkg::RX_DATA, 1'b0);
				end
			end
			spifcs_pkg::OP_READ_START: begin
				if (phase_q == spifcs_pkg::PH_IDLE) begin
					frame.count = 3'd4;
					frame.entry[0] = spifcs_pkg::mk_res(cfg.op_read_data, 1'b0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[1] = spifcs_pkg::mk_res(address[23:16], 1'b0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[2] = spifcs_pkg::mk_res(address[15:8], 1'b0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[3] = spifcs_pkg::mk_res(address[7:0], length == 16'd0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					if (length != 16'd0) begin
						addr_d  = address;
						rem_d   = length;
						phase_d = spifcs_pkg::PH_READ;
					end
				end
			end
			spifcs_pkg::OP_READ_BYTE: begin
				if (phase_q == spifcs_pkg::PH_READ) begin
					frame.count = 3'd1;
					frame.entry[0] = spifcs_pkg::mk_res(spifcs_pkg::DUMMY_BYTE,
						rem_dec == 16'd0, 1'b0, spifcs_pkg::RX_DATA, 1'b0);
					rem_d  = rem_dec;
					addr_d = addr_inc;
					if (rem_dec == 16'd0) begin
						phase_d = spifcs_pkg::PH_IDLE;
					end
				end
			end
			spifcs_pkg::OP_WRITE_START: begin
				if (phase_q == spifcs_pkg::PH_IDLE) begin
					if (length == 16'd0) begin
						frame.count = 3'd1;
						frame.entry[0] = spifcs_pkg::mk_res(8'd0, 1'b1, 1'b1,
							spifcs_pkg::RX_IGNORE, 1'b1);
					end else begin
						frame.count = 3'd5;
						frame.entry[0] = spifcs_pkg::mk_res(cfg.op_write_enable, 1'b1, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						frame.entry[1] = spifcs_pkg::mk_res(cfg.op_page_program, 1'b0, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						frame.entry[2] = spifcs_pkg::mk_res(address[23:16], 1'b0, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						frame.entry[3] = spifcs_pkg::mk_res(address[15:8], 1'b0, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						frame.entry[4] = spifcs_pkg::mk_res(address[7:0], 1'b0, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						addr_d  = address;
						rem_d   = length;
						phase_d = spifcs_pkg::PH_WRITE;
					end
				end
			end
			spifcs_pkg::OP_WRITE_BYTE: begin
				if (phase_q == spifcs_pkg::PH_WRITE) begin
					frame.count = page_end ? 3'd3 : 3'd1;
					frame.entry[0] = spifcs_pkg::mk_res(data, page_end, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[1] = spifcs_pkg::mk_res(cfg.op_read_status, 1'b0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[2] = spifcs_pkg::mk_res(spifcs_pkg::DUMMY_BYTE, 1'b0, 1'b0,
						spifcs_pkg::RX_STATUS, 1'b0);
					rem_d  = rem_dec;
					addr_d = addr_inc;
					if (page_end) begin
						poll_wr_d = 1'b1;
						phase_d   = spifcs_pkg::PH_POLL;
					end
				end
			end
			spifcs_pkg::OP_SECTOR_ERASE, spifcs_pkg::OP_BLOCK_ERASE: begin
				if (phase_q == spifcs_pkg::PH_IDLE) begin
					frame.count = 3'd7;
					frame.entry[0] = spifcs_pkg::mk_res(cfg.op_write_enable, 1'b1, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[1] = spifcs_pkg::mk_res(
						(operation == spifcs_pkg::OP_SECTOR_ERASE) ?
						cfg.op_sector_erase : cfg.op_block_erase,
						1'b0, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[2] = spifcs_pkg::mk_res(address[23:16], 1'b0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[3] = spifcs_pkg::mk_res(address[15:8], 1'b0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[4] = spifcs_pkg::mk_res(address[7:0], 1'b1, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[5] = spifcs_pkg::mk_res(cfg.op_read_status, 1'b0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[6] = spifcs_pkg::mk_res(spifcs_pkg::DUMMY_BYTE, 1'b0, 1'b0,
						spifcs_pkg::RX_STATUS, 1'b0);
					poll_wr_d = 1'b0;
					phase_d   = spifcs_pkg::PH_POLL;
				end
			end
			spifcs_pkg::OP_CHIP_ERASE: begin
				if (phase_q == spifcs_pkg::PH_IDLE) begin
					frame.count = 3'd4;
					frame.entry[0] = spifcs_pkg::mk_res(cfg.op_write_enable, 1'b1, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[1] = spifcs_pkg::mk_res(cfg.op_chip_erase, 1'b1, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[2] = spifcs_pkg::mk_res(cfg.op_read_status, 1'b0, 1'b0,
						spifcs_pkg::RX_IGNORE, 1'b0);
					frame.entry[3] = spifcs_pkg::mk_res(spifcs_pkg::DUMMY_BYTE, 1'b0, 1'b0,
						spifcs_pkg::RX_STATUS, 1'b0);
					poll_wr_d = 1'b0;
					phase_d   = spifcs_pkg::PH_POLL;
				end
			end
			spifcs_pkg::OP_STATUS: begin
				if (phase_q == spifcs_pkg::PH_POLL) begin
					if (data[spifcs_pkg::WIP_BIT]) begin
						frame.count = 3'd1;
						frame.entry[0] = spifcs_pkg::mk_res(spifcs_pkg::DUMMY_BYTE, 1'b0,
							1'b0, spifcs_pkg::RX_STATUS, 1'b0);
					end else if (poll_wr_q && rem_q != 16'd0) begin
						// release, then open the next page frame
						frame.count = 3'd6;
						frame.entry[0] = spifcs_pkg::mk_res(8'd0, 1'b1, 1'b1,
							spifcs_pkg::RX_IGNORE, 1'b0);
						frame.entry[1] = spifcs_pkg::mk_res(cfg.op_write_enable, 1'b1, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						frame.entry[2] = spifcs_pkg::mk_res(cfg.op_page_program, 1'b0, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						frame.entry[3] = spifcs_pkg::mk_res(addr_q[23:16], 1'b0, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						frame.entry[4] = spifcs_pkg::mk_res(addr_q[15:8], 1'b0, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						frame.entry[5] = spifcs_pkg::mk_res(addr_q[7:0], 1'b0, 1'b0,
							spifcs_pkg::RX_IGNORE, 1'b0);
						phase_d = spifcs_pkg::PH_WRITE;
					end else begin
						frame.count = 3'd1;
						frame.entry[0] = spifcs_pkg::mk_res(8'd0, 1'b1, 1'b1,
							spifcs_pkg::RX_IGNORE, 1'b1);
						phase_d = spifcs_pkg::PH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
		// anything not valid in this phase
		if (frame.count == '0) begin
			frame.count = 3'd1;
			frame.entry[0].rejected = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= spifcs_pkg::PH_IDLE;
			addr_q    <= '0;
			rem_q     <= '0;
			poll_wr_q <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_d;
			addr_q    <= addr_d;
			rem_q     <= rem_d;
			poll_wr_q <= poll_wr_d;
		end
	end

endmodule

// ===== src/spi_flash_command_sequencer_core.sv =====
// spi flash command sequencer
// request channel: in_valid/in_ready with operation, address, length and data.
// each request is turned into one to seven bus byte results, sent in bus order
// on out_valid/out_ready: tx_byte, select_end, release_only, rx_use, op_done,
// rejected, and last on the final result of the request.
// status bytes read back while polling return as status reply requests.
// latency: first result is valid the cycle after the request transaction.
// throughput: one result per cycle while out_ready is high, as the single-entry
// output frame register and its read index set that rate. a request is taken
// in the same cycle as the last result of the previous one leaves. opcodes are
// set through cfg_write/cfg_index/cfg_data; the user must do so only while idle,
// as the block itself does not enforce it.
// reset: phase idle, counters cleared, opcodes at their defaults, no result.
// a stalled receiver holds the current result; once the frame register is
// full, in_ready stays low until its last result is taken.
`include "assert_macros.svh"

module spi_flash_command_sequencer_core #(
	parameter int PAGE_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  operation,
	input  logic [23:0] address,
	input  logic [15:0] length,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  tx_byte,
	output logic        select_end,
	output logic        release_only,
	output logic [1:0]  rx_use,
	output logic        op_done,
	output logic        rejected,
	output logic        last,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	spifcs_pkg::cfg_t   cfg_q;
	spifcs_pkg::frame_t frame_d;
	spifcs_pkg::frame_t frame_s1;
	spifcs_pkg::result_t cur;
	logic [spifcs_pkg::CNT_W-1:0] idx_q;
	logic busy_q;
	logic take;
	logic out_fire;
	logic frame_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.op_write_enable <= 8'd6;
			cfg_q.op_read_status  <= 8'd5;
			cfg_q.op_page_program <= 8'd2;
			cfg_q.op_read_data    <= 8'd3;
			cfg_q.op_sector_erase <= 8'd32;
			cfg_q.op_block_erase  <= 8'd216;
			cfg_q.op_chip_erase   <= 8'd199;
			cfg_q.op_read_ident   <= 8'd159;
		end else if (cfg_write) begin
			case (cfg_index)
				spifcs_pkg::REG_WREN: cfg_q.op_write_enable <= cfg_data;
				spifcs_pkg::REG_RDSR: cfg_q.op_read_status  <= cfg_data;
				spifcs_pkg::REG_PP:   cfg_q.op_page_program <= cfg_data;
				spifcs_pkg::REG_READ: cfg_q.op_read_data    <= cfg_data;
				spifcs_pkg::REG_SE:   cfg_q.op_sector_erase <= cfg_data;
				spifcs_pkg::REG_BE:   cfg_q.op_block_erase  <= cfg_data;
				spifcs_pkg::REG_CE:   cfg_q.op_chip_erase   <= cfg_data;
				spifcs_pkg::REG_RDID: cfg_q.op_read_ident   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	spifcs_frame #(
		.PAGE_SIZE(PAGE_SIZE)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.operation (operation),
		.address   (address),
		.length    (length),
		.data      (data),
		.cfg       (cfg_q),
		.frame     (frame_d)
	);

	assign cur        = frame_s1.entry[idx_q];
	assign last       = (idx_q == frame_s1.count - 3'd1);
	assign out_valid  = busy_q;
	assign out_fire   = busy_q && out_ready;
	assign frame_done = out_fire && last;
	assign in_ready   = !busy_q || frame_done;
	assign take       = in_valid && in_ready;

	assign tx_byte      = cur.tx_byte;
	assign select_end   = cur.select_end;
	assign release_only = cur.release_only;
	assign rx_use       = cur.rx_use;
	assign op_done      = cur.op_done;
	assign rejected     = cur.rejected;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (frame_done) begin
			busy_q <= 1'b0;
		end else if (out_fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_s1 <= frame_d;
		end
	end

	`ASSERT_IMPLY(a_idx_in_frame, busy_q,
		(frame_s1.count != 3'd0) && (idx_q < frame_s1.count), "read index beyond frame")
	`ASSERT_NEXT(a_take_loads, take, busy_q && (idx_q == 3'd0), "request not loaded")
	`ASSERT_IMPLY(a_reject_alone, out_valid && rejected,
		last && (idx_q == 3'd0) && (tx_byte == 8'd0), "rejection not a lone result")
	`ASSERT_IMPLY(a_release_form, out_valid && release_only,
		select_end && (tx_byte == 8'd0) && last == (op_done || last), "bad release result")
	`ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(idx_q),
		"result moved under stall")

endmodule

// ===== dv/tb_spi_flash_command_sequencer_core.sv =====
`timescale 1ns / 100ps

module tb_spi_flash_command_sequencer_core;

	localparam int PAGE_BYTES = 256;
	localparam int STALL_CYCLES = 200;
	localparam int DRAIN_LIMIT = 5000;
	localparam spifcs_pkg::cfg_t OPC_DEFAULT =
		{8'd6, 8'd5, 8'd2, 8'd3, 8'd32, 8'd216, 8'd199, 8'd159};

	typedef struct packed {
		spifcs_pkg::result_t res;
		logic                last;
	} bus_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  operation;
	logic [23:0] address;
	logic [15:0] length;
	logic [7:0]  data;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  tx_byte;
	logic        select_end;
	logic        release_only;
	logic [1:0]  rx_use;
	logic        op_done;
	logic        rejected;
	logic        last;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	// flash sequencer copy
	spifcs_pkg::cfg_t    opc;
	spifcs_pkg::phase_t  phase;
	logic [23:0]         cur_addr;
	logic [15:0]         remain;
	logic                poll_write;

	bus_byte_t           bus_expected[$];
	spifcs_pkg::result_t staged;
	logic                have_staged;
	bus_byte_t           want;
	int                  errors;
	bit                  quiet;
	bit                  stall_req;

	spi_flash_command_sequencer_core #(
		.PAGE_SIZE(PAGE_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.address(address),
		.length(length),
		.data(data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_byte(tx_byte),
		.select_end(select_end),
		.release_only(release_only),
		.rx_use(rx_use),
		.op_done(op_done),
		.rejected(rejected),
		.last(last),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
		input logic [7:0] exp_val);
		if (got !== exp_val)
			report_error($sformatf("%s got %0h expected %0h", name, got, exp_val));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (bus_expected.size() == 0) begin
				report_error($sformatf("unexpected transaction, tx_byte %02h", tx_byte));
			end else begin
				want = bus_expected.pop_front();
				check_field("tx_byte", tx_byte, want.res.tx_byte);
				check_field("select_end", 8'(select_end), 8'(want.res.select_end));
				check_field("release_only", 8'(release_only), 8'(want.res.release_only));
				check_field("rx_use", 8'(rx_use), 8'(want.res.rx_use));
				check_field("op_done", 8'(op_done), 8'(want.res.op_done));
				check_field("rejected", 8'(rejected), 8'(want.res.rejected));
				check_field("last", 8'(last), 8'(want.last));
			end
		end
	end

	// receiver: random back-pressure plus one long hold when asked
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				hold = STALL_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	task automatic stage_byte(input logic [7:0] tx, input logic se, input logic rel,
		input logic [1:0] rx, input logic done, input logic rej);
		bus_byte_t e;
		if (have_staged) begin
			e.res = staged;
			e.last = 1'b0;
			bus_expected.push_back(e);
		end
		staged.tx_byte = tx;
		staged.select_end = se;
		staged.release_only = rel;
		staged.rx_use = rx;
		staged.op_done = done;
		staged.rejected = rej;
		have_staged = 1'b1;
	endtask

	task automatic stage_address(input logic [23:0] a, input logic end_frame);
		stage_byte(a[23:16], 1'b0, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
		stage_byte(a[15:8], 1'b0, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
		stage_byte(a[7:0], end_frame, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
	endtask

	task automatic open_page();
		stage_byte(opc.op_write_enable, 1'b1, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
		stage_byte(opc.op_page_program, 1'b0, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
		stage_address(cur_addr, 1'b0);
		phase = spifcs_pkg::PH_WRITE;
	endtask

	task automatic begin_poll(input logic is_write);
		stage_byte(opc.op_read_status, 1'b0, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
		stage_byte(spifcs_pkg::DUMMY_BYTE, 1'b0, 1'b0, spifcs_pkg::RX_STATUS, 1'b0, 1'b0);
		poll_write = is_write;
		phase = spifcs_pkg::PH_POLL;
	endtask

	task automatic predict_bus_bytes(input logic [3:0] op, input logic [23:0] addr,
		input logic [15:0] len, input logic [7:0] dat);
		bus_byte_t e;
		logic at_end;
		logic idle;
		idle = (phase == spifcs_pkg::PH_IDLE);
		if (op == spifcs_pkg::OP_READ_ID && idle) begin
			stage_byte(opc.op_read_ident, 1'b0, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
			stage_byte(spifcs_pkg::DUMMY_BYTE, 1'b0, 1'b0, spifcs_pkg::RX_DATA, 1'b0, 1'b0);
			stage_byte(spifcs_pkg::DUMMY_BYTE, 1'b0, 1'b0, spifcs_pkg::RX_DATA, 1'b0, 1'b0);
			stage_byte(spifcs_pkg::DUMMY_BYTE, 1'b1, 1'b0, spifcs_pkg::RX_DATA, 1'b0, 1'b0);
		end else if (op == spifcs_pkg::OP_READ_START && idle) begin
			stage_byte(opc.op_read_data, 1'b0, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
			stage_address(addr, len == 16'd0);
			if (len != 16'd0) begin
				cur_addr = addr;
				remain = len;
				phase = spifcs_pkg::PH_READ;
			end
		end else if (op == spifcs_pkg::OP_READ_BYTE && phase == spifcs_pkg::PH_READ) begin
			remain = remain - 16'd1;
			cur_addr = cur_addr + 24'd1;
			stage_byte(spifcs_pkg::DUMMY_BYTE, remain == 16'd0, 1'b0, spifcs_pkg::RX_DATA,
				1'b0, 1'b0);
			if (remain == 16'd0)
				phase = spifcs_pkg::PH_IDLE;
		end else if (op == spifcs_pkg::OP_WRITE_START && idle) begin
			if (len == 16'd0) begin
				stage_byte(8'h00, 1'b1, 1'b1, spifcs_pkg::RX_IGNORE, 1'b1, 1'b0);
			end else begin
				cur_addr = addr;
				remain = len;
				open_page();
			end
		end else if (op == spifcs_pkg::OP_WRITE_BYTE && phase == spifcs_pkg::PH_WRITE) begin
			remain = remain - 16'd1;
			cur_addr = cur_addr + 24'd1;
			at_end = (remain == 16'd0) || ((cur_addr % PAGE_BYTES) == 0);
			stage_byte(dat, at_end, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
			if (at_end)
				begin_poll(1'b1);
		end else if ((op == spifcs_pkg::OP_SECTOR_ERASE || op == spifcs_pkg::OP_BLOCK_ERASE)
			&& idle) begin
			stage_byte(opc.op_write_enable, 1'b1, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
			stage_byte(op == spifcs_pkg::OP_SECTOR_ERASE ? opc.op_sector_erase :
				opc.op_block_erase, 1'b0, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
			stage_address(addr, 1'b1);
			begin_poll(1'b0);
		end else if (op == spifcs_pkg::OP_CHIP_ERASE && idle) begin
			stage_byte(opc.op_write_enable, 1'b1, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
			stage_byte(opc.op_chip_erase, 1'b1, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
			begin_poll(1'b0);
		end else if (op == spifcs_pkg::OP_STATUS && phase == spifcs_pkg::PH_POLL) begin
			if (dat[spifcs_pkg::WIP_BIT]) begin
				stage_byte(spifcs_pkg::DUMMY_BYTE, 1'b0, 1'b0, spifcs_pkg::RX_STATUS,
					1'b0, 1'b0);
			end else if (poll_write && remain != 16'd0) begin
				stage_byte(8'h00, 1'b1, 1'b1, spifcs_pkg::RX_IGNORE, 1'b0, 1'b0);
				open_page();
			end else begin
				stage_byte(8'h00, 1'b1, 1'b1, spifcs_pkg::RX_IGNORE, 1'b1, 1'b0);
				phase = spifcs_pkg::PH_IDLE;
			end
		end else begin
			stage_byte(8'h00, 1'b0, 1'b0, spifcs_pkg::RX_IGNORE, 1'b0, 1'b1);
		end
		e.res = staged;
		e.last = 1'b1;
		bus_expected.push_back(e);
		have_staged = 1'b0;
	endtask

	task automatic send_req(input logic [3:0] op, input logic [23:0] addr,
		input logic [15:0] len, input logic [7:0] dat);
		while (!quiet && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		address <= addr;
		length <= len;
		data <= dat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_bus_bytes(op, addr, len, dat);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (bus_expected.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (bus_expected.size() != 0) begin
			report_error($sformatf("%0d transactions never arrived", bus_expected.size()));
			bus_expected.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_opcodes(input spifcs_pkg::cfg_t v);
		write_reg(spifcs_pkg::REG_WREN, v.op_write_enable);
		write_reg(spifcs_pkg::REG_RDSR, v.op_read_status);
		write_reg(spifcs_pkg::REG_PP, v.op_page_program);
		write_reg(spifcs_pkg::REG_READ, v.op_read_data);
		write_reg(spifcs_pkg::REG_SE, v.op_sector_erase);
		write_reg(spifcs_pkg::REG_BE, v.op_block_erase);
		write_reg(spifcs_pkg::REG_CE, v.op_chip_erase);
		write_reg(spifcs_pkg::REG_RDID, v.op_read_ident);
		cfg_write <= 1'b0;
		opc = v;
	endtask

	task automatic start_random_command();
		logic [23:0] a;
		logic [15:0] n;
		logic [7:0] d;
		int kind;
		a = 24'($urandom);
		d = 8'($urandom);
		kind = int'($urandom_range(0, 6));
		case (kind)
			0: send_req(spifcs_pkg::OP_READ_ID, a, 16'($urandom), d);
			1: begin
				n = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
				send_req(spifcs_pkg::OP_READ_START, a, n, d);
			end
			2, 3: begin
				n = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
				if ($urandom_range(0, 1))
					a[7:3] = 5'h1f;
				send_req(spifcs_pkg::OP_WRITE_START, a, n, d);
			end
			4: send_req(spifcs_pkg::OP_SECTOR_ERASE, a, 16'($urandom), d);
			5: send_req(spifcs_pkg::OP_BLOCK_ERASE, a, 16'($urandom), d);
			default: send_req(spifcs_pkg::OP_CHIP_ERASE, a, 16'($urandom), d);
		endcase
	endtask

	task automatic random_step();
		logic [23:0] a;
		logic [15:0] n;
		logic [7:0] d;
		logic [3:0] any_op;
		int pick;
		a = 24'($urandom);
		d = 8'($urandom);
		n = 16'($urandom);
		pick = int'($urandom_range(0, 99));
		if (pick < 12) begin
			// noise, mostly rejected in the current phase
			any_op = 4'($urandom_range(0, 15));
			send_req(any_op, a, 16'($urandom_range(0, 3)), d);
		end else begin
			case (phase)
				spifcs_pkg::PH_READ: send_req(spifcs_pkg::OP_READ_BYTE, a, n, d);
				spifcs_pkg::PH_WRITE: send_req(spifcs_pkg::OP_WRITE_BYTE, a, n, d);
				spifcs_pkg::PH_POLL: begin
					d[spifcs_pkg::WIP_BIT] = (pick < 45);
					send_req(spifcs_pkg::OP_STATUS, a, n, d);
				end
				default: start_random_command();
			endcase
		end
	endtask

	// bring the sequencer back to idle with well-formed requests
	task automatic finish_sequence();
		logic [7:0] d;
		while (phase != spifcs_pkg::PH_IDLE) begin
			d = 8'($urandom);
			case (phase)
				spifcs_pkg::PH_READ:
					send_req(spifcs_pkg::OP_READ_BYTE, 24'($urandom), 16'($urandom), d);
				spifcs_pkg::PH_WRITE:
					send_req(spifcs_pkg::OP_WRITE_BYTE, 24'($urandom), 16'($urandom), d);
				default: begin
					d[spifcs_pkg::WIP_BIT] = 1'b0;
					send_req(spifcs_pkg::OP_STATUS, 24'($urandom), 16'($urandom), d);
				end
			endcase
		end
	endtask

	task automatic test_read_id();
		send_req(spifcs_pkg::OP_READ_ID, 24'h000000, 16'h0000, 8'h00);
	endtask

	task automatic test_read();
		send_req(spifcs_pkg::OP_READ_BYTE, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_READ_START, 24'hffffff, 16'h0000, 8'hff);
		send_req(spifcs_pkg::OP_READ_START, 24'h000000, 16'h0002, 8'h00);
		send_req(spifcs_pkg::OP_READ_BYTE, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_READ_BYTE, 24'hffffff, 16'hffff, 8'hff);
	endtask

	task automatic test_write();
		send_req(spifcs_pkg::OP_WRITE_START, 24'h123456, 16'h0000, 8'h00);
		// starts on the last byte of the address space, so the first byte wraps
		send_req(spifcs_pkg::OP_WRITE_START, 24'hffffff, 16'h0003, 8'h00);
		send_req(spifcs_pkg::OP_WRITE_BYTE, 24'h000000, 16'h0000, 8'hff);
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'h01);
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'hfe);
		send_req(4'd15, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_WRITE_BYTE, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_WRITE_BYTE, 24'h000000, 16'h0000, 8'h5a);
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'h00);
	endtask

	task automatic test_erase();
		send_req(spifcs_pkg::OP_SECTOR_ERASE, 24'hffffff, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_BLOCK_ERASE, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'hff);
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_CHIP_ERASE, 24'h000000, 16'h0000, 8'h00);
		send_req(4'd9, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'h00);
	endtask

	task automatic test_opcode_extremes(input spifcs_pkg::cfg_t v);
		finish_sequence();
		drain();
		program_opcodes(v);
		test_read_id();
		send_req(spifcs_pkg::OP_READ_START, 24'($urandom), 16'h0000, 8'($urandom));
		send_req(spifcs_pkg::OP_SECTOR_ERASE, 24'($urandom), 16'h0000, 8'($urandom));
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'h03);
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_BLOCK_ERASE, 24'($urandom), 16'h0000, 8'($urandom));
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_CHIP_ERASE, 24'($urandom), 16'h0000, 8'($urandom));
		send_req(spifcs_pkg::OP_STATUS, 24'h000000, 16'h0000, 8'h00);
		send_req(spifcs_pkg::OP_WRITE_START, 24'h0000ff, 16'h0002, 8'h00);
		finish_sequence();
	endtask

	task automatic test_long_read();
		quiet = 1'b1;
		send_req(spifcs_pkg::OP_READ_START, 24'($urandom), 16'h0040, 8'($urandom));
		finish_sequence();
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		stall_req = 1'b1;
		repeat (20) random_step();
		finish_sequence();
		drain();
	endtask

	task automatic test_random(input int count, input spifcs_pkg::cfg_t v,
		input bit no_gaps);
		finish_sequence();
		drain();
		program_opcodes(v);
		quiet = no_gaps;
		repeat (count) random_step();
		quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		address = '0;
		length = '0;
		data = '0;
		out_ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		quiet = 1'b0;
		stall_req = 1'b0;
		have_staged = 1'b0;
		opc = OPC_DEFAULT;
		phase = spifcs_pkg::PH_IDLE;
		cur_addr = '0;
		remain = '0;
		poll_write = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_read_id();
		test_read();
		test_write();
		test_erase();
		test_opcode_extremes('0);
		test_opcode_extremes('1);
		test_long_read();
		test_backpressure();
		test_random(60, {$urandom, $urandom}, 1'b0);
		test_random(60, {$urandom, $urandom}, 1'b1);
		test_random(60, '1, 1'b0);
		test_random(60, OPC_DEFAULT, 1'b0);
		finish_sequence();

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/spifcs_pkg.sv
src/spifcs_frame.sv
src/spi_flash_command_sequencer_core.sv
dv/tb_spi_flash_command_sequencer_core.sv
